// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

	localparam int KEY_W = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;
	localparam logic [DATA_W-1:0] SET_VALUE = '0;

	// request kinds carried on s_tuser
	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} entry_t;

	// per-cell control from the top level
	typedef struct packed {
		logic valid;  // cell lies inside the occupied prefix
		logic shift;  // take the neighbor's entry this cycle
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

endpackage

// ===== rtl/lkvc_cell.sv =====
module lkvc_cell (
	input  logic                         clk,
	input  lkvc_pkg::cell_ctl_t          ctl,
	input  logic [lkvc_pkg::KEY_W-1:0]   cmp_key,
	input  lkvc_pkg::entry_t             prev,
	output lkvc_pkg::entry_t             cur,
	output logic                         match
);

	lkvc_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= prev;
		end
	end

	assign cur = entry_q;
	assign match = ctl.valid && (entry_q.key == cmp_key);

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// Entries sit in a row of cells ordered by recency: cell 0 holds the most
// recent entry and the occupied cells always form a prefix of the row, so
// the least recent entry is simply the last occupied cell. A request is a
// get (s_tuser low) or a set (s_tuser high) with key and value on s_tdata.
// Each request is registered first; then, in the lookup state, all
// cells compare the key in parallel and the row shifts by one place to
// bring the hit (or the new entry) to the front. The result sits in an
// output register, so a new request is taken while it waits on m_tready;
// the lookup stage only stalls when that register is still full.
// Writing cfg_wdata (capacity, 0 acts as 1, above ENTRIES acts as ENTRIES)
// empties the cache at once; write it only while no request is in flight.
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// capacity register
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // lookup_key [31:0], store_value [63:32]
	input  logic        s_tuser,   // operation: 0 get, 1 set
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_value [31:0]
	output logic [1:0]  m_tuser    // found [0], evicted [1]
);

	localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNTW = $clog2(ENTRIES + 1);
	localparam int CMPW = (CNTW > lkvc_pkg::CAP_W) ? CNTW : lkvc_pkg::CAP_W;
	localparam int KW = lkvc_pkg::KEY_W;
	localparam int DW = lkvc_pkg::DATA_W;

	lkvc_pkg::state_t state_q, state_d;

	// registered request
	logic          op_q;
	logic [KW-1:0] key_q;
	logic [DW-1:0] val_q;

	logic [lkvc_pkg::CAP_W-1:0] cap_q;
	logic [CNTW-1:0]            count_q;

	// result register
	logic          out_valid_q;
	logic [DW-1:0] out_data_q;
	logic          out_found_q;
	logic          out_evict_q;

	// lookup stage
	logic                 out_free;
	logic                 lookup_go;
	logic                 accept;
	logic [ENTRIES-1:0]   match;
	logic                 hit;
	logic [IDXW-1:0]      hit_idx;
	logic [DW-1:0]        hit_data;
	logic [CMPW-1:0]      cap_ext;
	logic [CMPW-1:0]      eff_cap;
	logic                 full;
	logic                 insert;
	logic                 do_update;

	lkvc_pkg::entry_t     cell_out [ENTRIES];
	lkvc_pkg::entry_t     cell_in  [ENTRIES];
	lkvc_pkg::cell_ctl_t  cell_ctl [ENTRIES];
	lkvc_pkg::entry_t     front;

	// fsm: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lkvc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = lkvc_pkg::ST_LOOKUP;
				end
			end
			lkvc_pkg::ST_LOOKUP: begin
				if (out_free) begin
					state_d = lkvc_pkg::ST_IDLE;
				end
			end
			default: state_d = lkvc_pkg::ST_IDLE;
		endcase
	end

	// fsm: outputs
	always_comb begin
		s_tready = 1'b0;
		lookup_go = 1'b0;
		case (state_q)
			lkvc_pkg::ST_IDLE:   s_tready = 1'b1;
			lkvc_pkg::ST_LOOKUP: lookup_go = out_free;
			default: begin
				s_tready = 1'b0;
				lookup_go = 1'b0;
			end
		endcase
	end

	assign out_free = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			key_q <= s_tdata[KW-1:0];
			val_q <= s_tdata[KW+DW-1:KW];
		end
	end

	// hit index and data, the match vector is one-hot or empty
	always_comb begin
		hit_idx = '0;
		hit_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | IDXW'(i);
				hit_data = hit_data | cell_out[i].data;
			end
		end
	end

	assign hit = |match;

	// effective capacity clamped to 1 .. ENTRIES
	assign cap_ext = CMPW'(cap_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_ext > CMPW'(ENTRIES)) begin
			eff_cap = CMPW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full = CMPW'(count_q) >= eff_cap;
	assign insert = lookup_go && (op_q == lkvc_pkg::OP_SET) && !hit;
	assign do_update = lookup_go && (hit || (op_q == lkvc_pkg::OP_SET));

	// entry that lands in the front cell
	assign front.key = key_q;
	assign front.data = (op_q == lkvc_pkg::OP_SET) ? val_q : hit_data;

	// row of cells, each shifts in its neighbor one place nearer the front
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign cell_in[g] = front;
		end else begin : g_body
			assign cell_in[g] = cell_out[g-1];
		end

		assign cell_ctl[g].valid = CNTW'(g) < count_q;
		// on an insert the whole row moves; on a hit only up to the hit cell
		assign cell_ctl[g].shift = insert || (do_update && hit && (IDXW'(g) <= hit_idx));

		lkvc_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[g]),
			.cmp_key (key_q),
			.prev    (cell_in[g]),
			.cur     (cell_out[g]),
			.match   (match[g])
		);
	end

	// capacity and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
			count_q <= '0;
		end else if (insert && !full) begin
			count_q <= count_q + CNTW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (lookup_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_go) begin
			out_found_q <= hit;
			out_evict_q <= insert && full;
			if (op_q == lkvc_pkg::OP_SET) begin
				out_data_q <= lkvc_pkg::SET_VALUE;
			end else if (hit) begin
				out_data_q <= hit_data;
			end else begin
				out_data_q <= lkvc_pkg::MISS_VALUE;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = {out_evict_q, out_found_q};

endmodule

// ===== rtl/lkvc_checker.sv =====
module lkvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// eviction only happens on a set miss
	a_evict_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("eviction reported on a hit");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
		else $error("eviction with nonzero read value");

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken during lookup");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== dv/lru_key_value_cache_test.sv =====
`timescale 1ns / 100ps

// checks the lru cache against its own recency-ordered model of the store
module lru_key_value_cache_test;

	localparam int CACHE_ENTRIES = 16;
	localparam int PHASE_COUNT = 10;
	localparam int PHASE_REQUESTS = 160;

	// one result as the block reports it
	typedef struct packed {
		logic                        found;
		logic [lkvc_pkg::DATA_W-1:0] value;
		logic                        evicted;
	} cache_result_t;

	// a row of the directed table is either a capacity write or a request
	typedef enum logic {
		ROW_CAPACITY,
		ROW_REQUEST
	} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic                        op;
		logic [lkvc_pkg::KEY_W-1:0]  key;
		logic [lkvc_pkg::DATA_W-1:0] value;   // capacity for a capacity row
		logic                        typed;   // expected result given below
		cache_result_t               want;
	} plan_row_t;

	localparam cache_result_t GET_MISS = '{1'b0, lkvc_pkg::MISS_VALUE, 1'b0};
	localparam cache_result_t SET_NEW = '{1'b0, lkvc_pkg::SET_VALUE, 1'b0};
	localparam cache_result_t SET_UPDATE = '{1'b1, lkvc_pkg::SET_VALUE, 1'b0};
	localparam cache_result_t SET_EVICT = '{1'b0, lkvc_pkg::SET_VALUE, 1'b1};

	// directed part: extremes, both operations, capacity corner cases
	plan_row_t test_plan [26] = '{
		// empty after reset, capacity 16
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, GET_MISS},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h8000_0000, 32'h7fff_ffff, 1'b1, SET_NEW},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
			'{1'b1, 32'h7fff_ffff, 1'b0}},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h7fff_ffff, 32'h8000_0000, 1'b1, SET_NEW},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h7fff_ffff, 32'hffff_ffff, 1'b1,
			'{1'b1, 32'h8000_0000, 1'b0}},
		// a stored -1 is told apart from a miss only by found
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'hffff_ffff, 32'hffff_ffff, 1'b1, SET_NEW},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hffff_ffff, 1'b0}},
		// update of a present key
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h8000_0000, 32'h0000_0000, 1'b1,
			SET_UPDATE},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
			'{1'b1, 32'h0000_0000, 1'b0}},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h0000_0001, 32'hffff_ffff, 1'b1, GET_MISS},
		// capacity zero acts as one entry
		'{ROW_CAPACITY, lkvc_pkg::OP_GET, 32'h0, 32'd0, 1'b0, '0},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h0000_0005, 32'h0000_0055, 1'b1, SET_NEW},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h0000_0006, 32'h0000_0066, 1'b1, SET_EVICT},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b1, GET_MISS},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h0000_0006, 32'h0000_0000, 1'b1,
			'{1'b1, 32'h0000_0066, 1'b0}},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h0000_0006, 32'h0000_0077, 1'b1,
			SET_UPDATE},
		// capacity two: a get makes its entry most recent
		'{ROW_CAPACITY, lkvc_pkg::OP_GET, 32'h0, 32'd2, 1'b0, '0},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h0000_00a1, 32'h0000_0001, 1'b0, '0},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h0000_00b2, 32'h0000_0002, 1'b0, '0},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h0000_00a1, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h0000_00c3, 32'h0000_0003, 1'b0, '0},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h0000_00b2, 32'h0000_0000, 1'b0, '0},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h0000_00a1, 32'h0000_0000, 1'b0, '0},
		// capacity above the store size, and the write empties the store
		'{ROW_CAPACITY, lkvc_pkg::OP_GET, 32'h0, 32'd31, 1'b0, '0},
		'{ROW_REQUEST, lkvc_pkg::OP_GET, 32'h0000_00a1, 32'h0000_0000, 1'b1, GET_MISS},
		'{ROW_REQUEST, lkvc_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000, 1'b1, SET_NEW}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [lkvc_pkg::CAP_W-1:0]  cfg_wdata;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [63:0]                 s_tdata;    // lookup_key [31:0], store_value [63:32]
	logic                        s_tuser;    // operation
	logic                        m_tvalid;
	logic                        m_tready;
	logic [31:0]                 m_tdata;    // read_value
	logic [1:0]                  m_tuser;    // found [0], evicted [1]

	// model of the store: entry 0 is the most recent
	logic [lkvc_pkg::KEY_W-1:0]  recent_keys [$];
	logic [lkvc_pkg::DATA_W-1:0] recent_data [$];
	logic [lkvc_pkg::CAP_W-1:0]  capacity_reg;

	// results owed by the block, oldest first
	cache_result_t     pending_results [$];

	int                idle_pct;      // sender idles this share of cycles
	int                stall_pct;     // receiver stalls this share of cycles
	int                error_count;

	lru_key_value_cache #(
		.ENTRIES(CACHE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// 0 acts as 1, anything above the store size as the store size
	function automatic int usable_capacity();
		if (capacity_reg == '0)
			return 1;
		if (capacity_reg > CACHE_ENTRIES)
			return CACHE_ENTRIES;
		return int'(capacity_reg);
	endfunction

	// result of one request, moving the model's store along
	function automatic cache_result_t lookup_and_update(logic op,
			logic [lkvc_pkg::KEY_W-1:0] key, logic [lkvc_pkg::DATA_W-1:0] value);
		cache_result_t               res;
		int                          hit;
		logic [lkvc_pkg::DATA_W-1:0] data;
		res = (op == lkvc_pkg::OP_SET) ? SET_NEW : GET_MISS;
		hit = -1;
		foreach (recent_keys[i])
			if (hit < 0 && recent_keys[i] == key)
				hit = i;
		if (hit >= 0) begin
			// hit: read or overwrite, then move to the front
			res.found = 1'b1;
			data = recent_data[hit];
			if (op == lkvc_pkg::OP_GET)
				res.value = data;
			else
				data = value;
			recent_keys.delete(hit);
			recent_data.delete(hit);
			recent_keys.push_front(key);
			recent_data.push_front(data);
		end else if (op == lkvc_pkg::OP_SET) begin
			// miss on a set: drop the least recent entry when full
			if (recent_keys.size() >= usable_capacity()) begin
				void'(recent_keys.pop_back());
				void'(recent_data.pop_back());
				res.evicted = 1'b1;
			end
			recent_keys.push_front(key);
			recent_data.push_front(value);
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// receiver: check each accepted result, then pick the next ready
	always @(posedge clk) begin
		cache_result_t got;
		cache_result_t want;
		if (m_tvalid && m_tready) begin
			got = '{m_tuser[0], m_tdata, m_tuser[1]};
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request waiting", m_tdata, '0);
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found)
					report_mismatch("found", 32'(got.found), 32'(want.found));
				if (got.value !== want.value)
					report_mismatch("read_value", got.value, want.value);
				if (got.evicted !== want.evicted)
					report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// one request through the handshake, with random idle cycles ahead of it
	task automatic send_request(logic op, logic [lkvc_pkg::KEY_W-1:0] key,
			logic [lkvc_pkg::DATA_W-1:0] value, logic typed, cache_result_t want);
		cache_result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {value, key};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// accepted at this edge; the model moves even where the result is typed
		predicted = lookup_and_update(op, key, value);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// stop sending until every owed result is back, then let the pipe settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity write, only with the block idle; it empties the store
	task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = cap;
		recent_keys.delete();
		recent_data.delete();
	endtask

	// stimulus
	initial begin
		logic [lkvc_pkg::KEY_W-1:0] key_pool [CACHE_ENTRIES + 4];
		int                         phase_caps [PHASE_COUNT];
		int                         pool_size;
		logic [lkvc_pkg::CAP_W-1:0] cap;
		logic [lkvc_pkg::KEY_W-1:0] key;
		phase_caps = '{1, 0, 2, 16, 31, 3, 8, 17, 5, 0};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= lkvc_pkg::OP_GET;
		m_tready <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		error_count = 0;
		capacity_reg = lkvc_pkg::CAP_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling on either side
		foreach (test_plan[i]) begin
			if (test_plan[i].kind == ROW_CAPACITY)
				write_capacity(test_plan[i].value[lkvc_pkg::CAP_W-1:0]);
			else
				send_request(test_plan[i].op, test_plan[i].key, test_plan[i].value,
					test_plan[i].typed, test_plan[i].want);
		end

		// random phases, each with its own capacity and idling pattern
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			cap = (phase == PHASE_COUNT - 1) ? lkvc_pkg::CAP_W'($urandom_range(31)) :
				lkvc_pkg::CAP_W'(phase_caps[phase]);
			write_capacity(cap);
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 64;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 64;
				end
				default: begin
					idle_pct = 20;
					stall_pct = 20;
				end
			endcase
			// a key pool a little larger than the capacity keeps hits and evictions coming
			pool_size = usable_capacity() + $urandom_range(1, 4);
			for (int k = 0; k < pool_size; k++)
				key_pool[k] = $urandom();
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				// let the block run dry once per phase
				if (n == PHASE_REQUESTS / 2)
					drain_results();
				if ($urandom_range(99) < 85)
					key = key_pool[$urandom_range(pool_size - 1)];
				else
					key = $urandom();
				send_request(logic'($urandom_range(1)), key, $urandom(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
